/* rtl/assert_macros.svh */
// Assertion helpers, clocked on the rising edge and off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rrt_pkg.sv */
`timescale 1ns / 1ps

package rrt_pkg;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_PROV = 2'd2;
    localparam logic [1:0] PH_TERM = 2'd3;

    localparam logic [1:0] MODE_MSG      = 2'd0;
    localparam logic [1:0] MODE_RESEND   = 2'd1;
    localparam logic [1:0] MODE_LIFETIME = 2'd2;

    localparam logic [1:0] K_REQ   = 2'd0;
    localparam logic [1:0] K_FINAL = 2'd1;
    localparam logic [1:0] K_PROV  = 2'd2;

    localparam logic [2:0] V_NONE    = 3'd0;
    localparam logic [2:0] V_FORWARD = 3'd1;
    localparam logic [2:0] V_REFUSE  = 3'd2;
    localparam logic [2:0] V_RESEND  = 3'd3;
    localparam logic [2:0] V_TIMEOUT = 3'd4;

    localparam logic [1:0] R_NONE = 2'd0;
    localparam logic [1:0] R_100  = 2'd1;
    localparam logic [1:0] R_COPY = 2'd2;
    localparam logic [1:0] R_408  = 2'd3;

    localparam logic [1:0] T_NONE  = 2'd0;
    localparam logic [1:0] T_START = 2'd1;
    localparam logic [1:0] T_STOP  = 2'd2;

    localparam logic [1:0] C_NONE    = 2'd0;
    localparam logic [1:0] C_STORE   = 2'd1;
    localparam logic [1:0] C_DISCARD = 2'd2;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [1:0] phase;
        logic       final_required;
        logic       timer_armed;
        logic       cache_valid;
        logic [1:0] last_from_phase;
    } ctx_t;

    // Declared high to low so the verdict lands in the lowest bits.
    typedef struct packed {
        logic [1:0] prior_phase;
        logic       phase_changed;
        logic [1:0] new_phase;
        logic [1:0] cache_action;
        logic [1:0] timer_action;
        logic [1:0] reply_kind;
        logic [2:0] verdict;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

/* rtl/rrt_decide.sv */
`timescale 1ns / 1ps

module rrt_decide (
    input  rrt_pkg::ctx_t ctx,
    input  logic          client_role,
    input  logic [1:0]    mode,
    input  logic [1:0]    msg_kind,
    input  logic          needs_final,
    output rrt_pkg::ctx_t ctx_next,
    output rrt_pkg::res_t res
);
    import rrt_pkg::*;

    logic [1:0] move_phase;
    logic       do_move;

    always_comb begin
        ctx_next   = ctx;
        res        = '0;
        move_phase = ctx.phase;
        do_move    = 1'b0;

        case (mode)
            MODE_MSG: begin
                if (client_role) begin
                    case (ctx.phase)
                        PH_IDLE: begin
                            if (msg_kind == K_REQ) begin
                                res.cache_action        = C_STORE;
                                ctx_next.cache_valid    = 1'b1;
                                res.timer_action        = T_START;
                                ctx_next.timer_armed    = 1'b1;
                                ctx_next.final_required = needs_final;
                                move_phase              = PH_FWD;
                                do_move                 = 1'b1;
                                res.verdict             = V_FORWARD;
                            end
                        end
                        PH_FWD: begin
                            if (msg_kind inside {K_FINAL, K_PROV}) begin
                                if (ctx.timer_armed) begin
                                    res.timer_action     = T_STOP;
                                    ctx_next.timer_armed = 1'b0;
                                end
                                if (ctx.cache_valid) begin
                                    res.cache_action     = C_DISCARD;
                                    ctx_next.cache_valid = 1'b0;
                                end
                                do_move = 1'b1;
                                if (msg_kind == K_FINAL) begin
                                    move_phase  = PH_TERM;
                                    res.verdict = V_FORWARD;
                                end else begin
                                    move_phase = ctx.final_required ? PH_PROV : PH_TERM;
                                end
                            end
                        end
                        PH_PROV: begin
                            if (msg_kind == K_FINAL) begin
                                res.reply_kind = R_100;
                                move_phase     = PH_TERM;
                                do_move        = 1'b1;
                                res.verdict    = V_FORWARD;
                            end
                        end
                        default: begin
                            if (msg_kind == K_FINAL) begin
                                res.reply_kind = R_100;
                                res.verdict    = V_REFUSE;
                            end
                        end
                    endcase
                end else begin
                    case (ctx.phase)
                        PH_IDLE: begin
                            if (msg_kind == K_REQ) begin
                                ctx_next.final_required = needs_final;
                                do_move                 = 1'b1;
                                if (needs_final) begin
                                    move_phase = PH_FWD;
                                end else begin
                                    move_phase     = PH_TERM;
                                    res.reply_kind = R_100;
                                end
                                res.verdict = V_FORWARD;
                            end
                        end
                        PH_FWD: begin
                            if (msg_kind == K_REQ) begin
                                move_phase     = PH_PROV;
                                do_move        = 1'b1;
                                res.reply_kind = R_100;
                                res.verdict    = V_REFUSE;
                            end else if (msg_kind == K_FINAL) begin
                                res.cache_action     = C_STORE;
                                ctx_next.cache_valid = 1'b1;
                                move_phase           = PH_TERM;
                                do_move              = 1'b1;
                                res.verdict          = V_FORWARD;
                            end
                        end
                        PH_PROV: begin
                            if (msg_kind == K_FINAL) begin
                                res.cache_action     = C_STORE;
                                ctx_next.cache_valid = 1'b1;
                                res.timer_action     = T_START;
                                ctx_next.timer_armed = 1'b1;
                                move_phase           = PH_TERM;
                                do_move              = 1'b1;
                                res.verdict          = V_FORWARD;
                            end else if (msg_kind == K_REQ) begin
                                res.reply_kind = R_100;
                                res.verdict    = V_REFUSE;
                            end
                        end
                        default: begin
                            if (msg_kind == K_REQ) begin
                                if (ctx.cache_valid) begin
                                    res.reply_kind = R_COPY;
                                    res.verdict    = V_REFUSE;
                                end else if (!ctx.final_required) begin
                                    res.reply_kind = R_100;
                                    res.verdict    = V_REFUSE;
                                end
                            end else if (msg_kind == K_PROV) begin
                                if (ctx.timer_armed) begin
                                    res.timer_action     = T_STOP;
                                    ctx_next.timer_armed = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            MODE_RESEND: begin
                if (ctx.timer_armed &&
                    ((client_role && ctx.phase == PH_FWD) ||
                     (!client_role && ctx.phase == PH_TERM))) begin
                    if (ctx.cache_valid) begin
                        res.reply_kind = R_COPY;
                    end
                    res.timer_action = T_START;
                    res.verdict      = V_RESEND;
                end
            end
            MODE_LIFETIME: begin
                if (client_role && ctx.cache_valid &&
                    (ctx.phase == PH_FWD || ctx.phase == PH_PROV)) begin
                    res.reply_kind = R_408;
                    res.verdict    = V_TIMEOUT;
                end
                if (ctx.timer_armed) begin
                    res.timer_action     = T_STOP;
                    ctx_next.timer_armed = 1'b0;
                end
                if (ctx.cache_valid) begin
                    res.cache_action     = C_DISCARD;
                    ctx_next.cache_valid = 1'b0;
                end
                ctx_next.final_required = 1'b0;
                if (ctx.phase != PH_IDLE) begin
                    move_phase = PH_IDLE;
                    do_move    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_move) begin
            ctx_next.last_from_phase = ctx.phase;
            ctx_next.phase           = move_phase;
        end
        res.new_phase     = ctx_next.phase;
        res.phase_changed = do_move;
        res.prior_phase   = ctx_next.last_from_phase;
    end

endmodule

/* rtl/rrt_ctx.sv */
`timescale 1ns / 1ps

module rrt_ctx (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          update,
    input  rrt_pkg::ctx_t ctx_next,
    output rrt_pkg::ctx_t ctx
);
    import rrt_pkg::*;

    ctx_t ctx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= '0;
        end else if (update) begin
            ctx_reg <= ctx_next;
        end
    end

    assign ctx = ctx_reg;

endmodule

/* rtl/request_response_transaction_fsm_unit.sv */
`timescale 1ns / 1ps
// An accepted word passes the input register, the decision logic and the result register,
// which drives m_tvalid. Throughput: one word per cycle while m_tready does not stall
// the output; the transaction context updates once per word.
// Reset (aresetn low, synchronous): phase idle, timer and cache flags clear,
// client_role 0, both word registers empty.

module request_response_transaction_fsm_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,     // client_role
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rrt_pkg::S_TDATA_W-1:0] s_tdata,     // [0] needs_final
    input  logic [rrt_pkg::S_TUSER_W-1:0] s_tuser,     // [1:0] mode, [3:2] msg_kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] verdict, [4:3] reply_kind, [6:5] timer_action, [8:7] cache_action,
    // [10:9] new_phase, [11] phase_changed, [13:12] prior_phase
    output logic [rrt_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrt_pkg::*;

    `include "assert_macros.svh"

    logic                 client_role_reg;
    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [1:0]           in_kind_reg;
    logic                 in_nf_reg;
    logic                 out_valid_reg;
    res_t                 out_res_reg;
    logic                 advance;
    logic                 s_accept;
    ctx_t                 ctx;
    ctx_t                 ctx_next;
    res_t                 res;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_role_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            client_role_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= s_tuser[1:0];
            in_kind_reg <= s_tuser[3:2];
            in_nf_reg   <= s_tdata[0];
        end
    end

    rrt_decide u_decide (
        .ctx         (ctx),
        .client_role (client_role_reg),
        .mode        (in_mode_reg),
        .msg_kind    (in_kind_reg),
        .needs_final (in_nf_reg),
        .ctx_next    (ctx_next),
        .res         (res)
    );

    rrt_ctx u_ctx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (advance && in_valid_reg),
        .ctx_next (ctx_next),
        .ctx      (ctx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), out_res_reg};

    `ASSERT_IMPL(a_idle_no_pending, aclk, aresetn, ctx.phase == PH_IDLE,
                 !ctx.timer_armed && !ctx.cache_valid)
    `ASSERT_IMPL(a_change_moves, aclk, aresetn, out_valid_reg && out_res_reg.phase_changed,
                 out_res_reg.new_phase != out_res_reg.prior_phase)
    `ASSERT_NEXT(a_ctx_matches_out, aclk, aresetn, advance && in_valid_reg,
                 ctx.phase == out_res_reg.new_phase && out_valid_reg)
    `ASSERT_IMPL(a_verdict_range, aclk, aresetn, out_valid_reg,
                 out_res_reg.verdict <= V_TIMEOUT)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import rrt_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] K_OTHER     = 2'd3;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         WORD_TARGET = 1450;

    typedef struct {
        bit         is_cfg;
        logic       role;
        logic [1:0] mode;
        logic [1:0] kind;
        logic       nf;
        bit         fixed;
        res_t       want;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [0] needs_final
    logic [S_TUSER_W-1:0] s_tuser   = '0;   // [1:0] mode, [3:2] msg_kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] verdict, [4:3] reply_kind, [6:5] timer_action, [8:7] cache_action,
    // [10:9] new_phase, [11] phase_changed, [13:12] prior_phase
    logic [M_TDATA_W-1:0] m_tdata;

    logic       row_fixed = 1'b0;
    res_t       row_want  = '0;
    bit         calm      = 1'b0;
    int         errors    = 0;
    res_t       pending_outcomes[$];
    stim_row_t  script_rows[$];

    logic       role_client    = 1'b0;
    logic [1:0] txn_phase      = PH_IDLE;
    logic       txn_need_final = 1'b0;
    logic       txn_timer_on   = 1'b0;
    logic       txn_cached     = 1'b0;
    logic [1:0] txn_from_phase = PH_IDLE;

    request_response_transaction_fsm_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic res_t predict_outcome(logic [1:0] md, logic [1:0] kd, logic nf);
        res_t       r;
        logic       moved;
        logic [1:0] nxt;
        r = '0;
        moved = 1'b0;
        nxt = txn_phase;
        if (md == MODE_MSG && role_client) begin
            case (txn_phase)
                PH_IDLE: if (kd == K_REQ) begin
                    r.cache_action = C_STORE;
                    txn_cached = 1'b1;
                    r.timer_action = T_START;
                    txn_timer_on = 1'b1;
                    txn_need_final = nf;
                    moved = 1'b1;
                    nxt = PH_FWD;
                    r.verdict = V_FORWARD;
                end
                PH_FWD: if (kd == K_FINAL || kd == K_PROV) begin
                    if (txn_timer_on) begin
                        r.timer_action = T_STOP;
                        txn_timer_on = 1'b0;
                    end
                    if (txn_cached) begin
                        r.cache_action = C_DISCARD;
                        txn_cached = 1'b0;
                    end
                    moved = 1'b1;
                    if (kd == K_FINAL) begin
                        nxt = PH_TERM;
                        r.verdict = V_FORWARD;
                    end else begin
                        nxt = txn_need_final ? PH_PROV : PH_TERM;
                    end
                end
                PH_PROV: if (kd == K_FINAL) begin
                    r.reply_kind = R_100;
                    moved = 1'b1;
                    nxt = PH_TERM;
                    r.verdict = V_FORWARD;
                end
                default: if (kd == K_FINAL) begin
                    r.reply_kind = R_100;
                    r.verdict = V_REFUSE;
                end
            endcase
        end else if (md == MODE_MSG) begin
            case (txn_phase)
                PH_IDLE: if (kd == K_REQ) begin
                    txn_need_final = nf;
                    moved = 1'b1;
                    nxt = nf ? PH_FWD : PH_TERM;
                    if (!nf) r.reply_kind = R_100;
                    r.verdict = V_FORWARD;
                end
                PH_FWD: if (kd == K_REQ) begin
                    moved = 1'b1;
                    nxt = PH_PROV;
                    r.reply_kind = R_100;
                    r.verdict = V_REFUSE;
                end else if (kd == K_FINAL) begin
                    r.cache_action = C_STORE;
                    txn_cached = 1'b1;
                    moved = 1'b1;
                    nxt = PH_TERM;
                    r.verdict = V_FORWARD;
                end
                PH_PROV: if (kd == K_FINAL) begin
                    r.cache_action = C_STORE;
                    txn_cached = 1'b1;
                    r.timer_action = T_START;
                    txn_timer_on = 1'b1;
                    moved = 1'b1;
                    nxt = PH_TERM;
                    r.verdict = V_FORWARD;
                end else if (kd == K_REQ) begin
                    r.reply_kind = R_100;
                    r.verdict = V_REFUSE;
                end
                default: if (kd == K_REQ) begin
                    if (txn_cached) begin
                        r.reply_kind = R_COPY;
                        r.verdict = V_REFUSE;
                    end else if (!txn_need_final) begin
                        r.reply_kind = R_100;
                        r.verdict = V_REFUSE;
                    end
                end else if (kd == K_PROV && txn_timer_on) begin
                    r.timer_action = T_STOP;
                    txn_timer_on = 1'b0;
                end
            endcase
        end else if (md == MODE_RESEND) begin
            if (txn_timer_on && (role_client ? txn_phase == PH_FWD : txn_phase == PH_TERM)) begin
                if (txn_cached) r.reply_kind = R_COPY;
                r.timer_action = T_START;
                r.verdict = V_RESEND;
            end
        end else if (md == MODE_LIFETIME) begin
            if (role_client && (txn_phase == PH_FWD || txn_phase == PH_PROV) && txn_cached) begin
                r.reply_kind = R_408;
                r.verdict = V_TIMEOUT;
            end
            if (txn_timer_on) begin
                r.timer_action = T_STOP;
                txn_timer_on = 1'b0;
            end
            if (txn_cached) begin
                r.cache_action = C_DISCARD;
                txn_cached = 1'b0;
            end
            txn_need_final = 1'b0;
            if (txn_phase != PH_IDLE) begin
                moved = 1'b1;
                nxt = PH_IDLE;
            end
        end
        if (moved) begin
            txn_from_phase = txn_phase;
            txn_phase = nxt;
        end
        r.new_phase = txn_phase;
        r.phase_changed = moved;
        r.prior_phase = txn_from_phase;
        return r;
    endfunction

    function automatic res_t outcome(logic [2:0] v, logic [1:0] rk, logic [1:0] ta,
                                     logic [1:0] ca, logic [1:0] np, logic ch, logic [1:0] pp);
        res_t r;
        r.verdict = v;
        r.reply_kind = rk;
        r.timer_action = ta;
        r.cache_action = ca;
        r.new_phase = np;
        r.phase_changed = ch;
        r.prior_phase = pp;
        return r;
    endfunction

    function automatic stim_row_t word_row(logic [1:0] md, logic [1:0] kd, logic nf);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.role = 1'b0;
        row.mode = md;
        row.kind = kd;
        row.nf = nf;
        row.fixed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(logic [1:0] md, logic [1:0] kd, logic nf,
                                            res_t want);
        stim_row_t row;
        row = word_row(md, kd, nf);
        row.fixed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic stim_row_t role_row(logic role);
        stim_row_t row;
        row = word_row(MODE_MSG, K_REQ, 1'b0);
        row.is_cfg = 1'b1;
        row.role = role;
        return row;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic send_word(logic [1:0] md, logic [1:0] kd, logic nf, bit fixed, res_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= {kd, md};
        s_tdata   <= {{(S_TDATA_W - 1){1'b0}}, nf};
        row_fixed <= fixed;
        row_want  <= want;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        row_fixed <= 1'b0;
        @(posedge aclk);
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic set_role(logic role);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= role;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[RES_W-1:0]);
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("verdict", want.verdict, got.verdict);
                    check_field("reply_kind", want.reply_kind, got.reply_kind);
                    check_field("timer_action", want.timer_action, got.timer_action);
                    check_field("cache_action", want.cache_action, got.cache_action);
                    check_field("new_phase", want.new_phase, got.new_phase);
                    check_field("phase_changed", want.phase_changed, got.phase_changed);
                    check_field("prior_phase", want.prior_phase, got.prior_phase);
                end
            end
            if (cfg_valid && cfg_ready) role_client = cfg_data;
            if (s_tvalid && s_tready) begin
                want = predict_outcome(s_tuser[1:0], s_tuser[3:2], s_tdata[0]);
                if (row_fixed) want = row_want;
                pending_outcomes.push_back(want);
            end
        end
    end

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (!aresetn) @(posedge aclk);
        do begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end while (quiet < QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int        sent;
        int        burst;
        int        pick;
        int        round;
        logic [1:0] md;
        logic [1:0] kd;
        stim_row_t row;

        script_rows.push_back(known_row(MODE_UNUSED, K_REQ, 1'b0, '0));
        script_rows.push_back(known_row(MODE_RESEND, K_FINAL, 1'b1, '0));
        script_rows.push_back(known_row(MODE_LIFETIME, K_PROV, 1'b0, '0));
        script_rows.push_back(known_row(MODE_MSG, K_OTHER, 1'b1, '0));
        script_rows.push_back(known_row(MODE_MSG, K_REQ, 1'b0,
            outcome(V_FORWARD, R_100, T_NONE, C_NONE, PH_TERM, 1'b1, PH_IDLE)));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_LIFETIME, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b1));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b1));
        script_rows.push_back(word_row(MODE_MSG, K_FINAL, 1'b0));
        script_rows.push_back(word_row(MODE_RESEND, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_PROV, 1'b1));
        script_rows.push_back(word_row(MODE_RESEND, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_LIFETIME, K_OTHER, 1'b1));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b1));
        script_rows.push_back(role_row(1'b1));
        script_rows.push_back(word_row(MODE_MSG, K_FINAL, 1'b0));
        script_rows.push_back(word_row(MODE_LIFETIME, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b1));
        script_rows.push_back(word_row(MODE_RESEND, K_PROV, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_PROV, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_FINAL, 1'b1));
        script_rows.push_back(word_row(MODE_MSG, K_FINAL, 1'b0));
        script_rows.push_back(word_row(MODE_LIFETIME, K_FINAL, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b0));
        script_rows.push_back(known_row(MODE_LIFETIME, K_REQ, 1'b0,
            outcome(V_TIMEOUT, R_408, T_STOP, C_DISCARD, PH_IDLE, 1'b1, PH_FWD)));
        script_rows.push_back(word_row(MODE_MSG, K_REQ, 1'b0));
        script_rows.push_back(word_row(MODE_MSG, K_PROV, 1'b1));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script_rows[i]) begin
            row = script_rows[i];
            if (row.is_cfg)
                set_role(row.role);
            else
                send_word(row.mode, row.kind, row.nf, row.fixed, row.want);
        end

        sent = 0;
        round = 0;
        while (sent < WORD_TARGET) begin
            set_role(round == 0 ? 1'b0 : round == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(20, 80);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                md = pick < 70 ? MODE_MSG : pick < 85 ? MODE_RESEND :
                     pick < 97 ? MODE_LIFETIME : MODE_UNUSED;
                pick = $urandom_range(0, 99);
                kd = pick < 35 ? K_REQ : pick < 65 ? K_FINAL : pick < 94 ? K_PROV : K_OTHER;
                send_word(md, kd, 1'($urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end
            round++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
